/* hw/rtl/cds_pkg.sv */
package cds_pkg;

	localparam int MAX_LEVELS = 64;
	localparam int DEPTH_W = $clog2(MAX_LEVELS + 1);
	localparam int LIMIT_W = 7;
	localparam int CMP_W = (DEPTH_W > LIMIT_W) ? DEPTH_W : LIMIT_W;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	typedef enum logic [1:0] {
		ACT_OPEN  = 2'd0,
		ACT_ELIF  = 2'd1,
		ACT_ELSE  = 2'd2,
		ACT_CLOSE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_NESTING    = 2'd1,
		ERR_UNEXPECTED = 2'd2,
		ERR_ELSE_AGAIN = 2'd3
	} error_t;

	typedef struct packed {
		logic else_seen;
		logic taken;
		logic live;
		logic parent;
	} frame_t;

	typedef struct packed {
		logic take_up;
		logic take_down;
	} shift_t;

endpackage

/* hw/rtl/conditional_directive_stack.sv */
// channel    | handshake          | payload
// -----------+--------------------+------------------------------------------
// directive  | start, busy        | action, condition
// result     | done (strobe)      | error_code, emitting_now,
//            |                    | evaluate_next_elif, open_levels
// config     | cfg_we             | cfg_wdata (nesting_limit)
//
// One directive per cycle; busy stays low. Each result appears in the cycle after
// its beat, for one cycle. The stack is a chain of frame cells with the top in
// cell 0: open shifts down, close shifts up, elif/else rewrite cell 0 only.
// Reset clears depth and strobe and sets the limit to 64; cell contents are not reset.
// The receiver cannot stall, so nothing is held back.
module conditional_directive_stack (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic                          condition,
	input  logic                          cfg_we,
	input  logic [cds_pkg::LIMIT_W-1:0]   cfg_wdata,
	output logic                          done,
	output logic [1:0]                    error_code,
	output logic                          emitting_now,
	output logic                          evaluate_next_elif,
	output logic [6:0]                    open_levels
);

	localparam int N = cds_pkg::MAX_LEVELS;
	localparam int DW = cds_pkg::DEPTH_W;

	logic [DW-1:0] depth_q;
	logic [cds_pkg::LIMIT_W-1:0] limit_q;
	logic done_q;
	logic [1:0] err_q;
	logic emit_q;
	logic elif_q;
	logic [6:0] levels_q;

	cds_pkg::frame_t frames [N];
	cds_pkg::frame_t top, second, new_frame, top_nx;
	cds_pkg::shift_t ctrl_top, ctrl_rest;
	cds_pkg::error_t err;
	logic [DW-1:0] depth_nx;
	logic empty, emits_cur, full, push, pop, modify, fire, live;

	assign busy = 1'b0;
	assign fire = start;
	assign top = frames[0];

	generate
		if (N > 1) begin : g_second
			assign second = frames[1];
		end else begin : g_no_second
			assign second = '0;
		end
	endgenerate

	always_comb begin
		empty = (depth_q == '0);
		emits_cur = empty | top.live;
		full = (cds_pkg::CMP_W'(depth_q) >= cds_pkg::CMP_W'(limit_q)) ||
			(depth_q >= DW'(N));
		push = 1'b0;
		pop = 1'b0;
		modify = 1'b0;
		err = cds_pkg::ERR_NONE;
		new_frame = top;
		live = 1'b0;
		case (cds_pkg::action_t'(action))
			cds_pkg::ACT_OPEN: begin
				if (full) begin
					err = cds_pkg::ERR_NESTING;
				end else begin
					push = 1'b1;
					new_frame.parent = emits_cur;
					new_frame.live = emits_cur & condition;
					new_frame.taken = emits_cur & condition;
					new_frame.else_seen = 1'b0;
				end
			end
			default: begin
				if (empty) begin
					err = cds_pkg::ERR_UNEXPECTED;
				end else if (cds_pkg::action_t'(action) == cds_pkg::ACT_CLOSE) begin
					pop = 1'b1;
				end else if (top.else_seen) begin
					err = cds_pkg::ERR_ELSE_AGAIN;
				end else if (cds_pkg::action_t'(action) == cds_pkg::ACT_ELIF) begin
					modify = 1'b1;
					live = top.parent & ~top.taken & condition;
					new_frame.live = live;
					new_frame.taken = top.taken | live;
				end else begin
					modify = 1'b1;
					new_frame.live = top.parent & ~top.taken;
					new_frame.taken = 1'b1;
					new_frame.else_seen = 1'b1;
				end
			end
		endcase

		ctrl_top.take_up = fire & (push | modify);
		ctrl_top.take_down = fire & pop;
		ctrl_rest.take_up = fire & push;
		ctrl_rest.take_down = fire & pop;

		depth_nx = depth_q;
		top_nx = top;
		if (push) begin
			depth_nx = depth_q + DW'(1);
			top_nx = new_frame;
		end else if (pop) begin
			depth_nx = depth_q - DW'(1);
			top_nx = second;
		end else if (modify) begin
			top_nx = new_frame;
		end
	end

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			cds_pkg::frame_t up_f, down_f;
			if (i == 0) begin : g_head
				assign up_f = new_frame;
			end else begin : g_body
				assign up_f = frames[i-1];
			end
			if (i == N - 1) begin : g_tail
				assign down_f = '0;
			end else begin : g_link
				assign down_f = frames[i+1];
			end
			cds_cell u_cell (
				.clk        (clk),
				.ctrl       ((i == 0) ? ctrl_top : ctrl_rest),
				.up_frame   (up_f),
				.down_frame (down_f),
				.frame      (frames[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			limit_q <= cds_pkg::LIMIT_RESET;
			done_q <= 1'b0;
		end else begin
			done_q <= fire;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (fire) begin
				depth_q <= depth_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			err_q <= err;
			emit_q <= (depth_nx == '0) | top_nx.live;
			elif_q <= (depth_nx != '0) & top_nx.parent & ~top_nx.taken &
				~top_nx.else_seen;
			levels_q <= 7'(depth_nx);
		end
	end

	assign done = done_q;
	assign error_code = err_q;
	assign emitting_now = emit_q;
	assign evaluate_next_elif = elif_q;
	assign open_levels = levels_q;

endmodule

/* hw/rtl/cds_cell.sv */
module cds_cell (
	input  logic            clk,
	input  cds_pkg::shift_t ctrl,
	input  cds_pkg::frame_t up_frame,
	input  cds_pkg::frame_t down_frame,
	output cds_pkg::frame_t frame
);

	cds_pkg::frame_t frame_q;

	always_ff @(posedge clk) begin
		if (ctrl.take_up) begin
			frame_q <= up_frame;
		end else if (ctrl.take_down) begin
			frame_q <= down_frame;
		end
	end

	assign frame = frame_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 400;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		cds_pkg::error_t err;
		logic            emit;
		logic            want_elif;
		logic [6:0]      levels;
	} result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic [1:0]                  action = cds_pkg::ACT_OPEN;
	logic                        condition = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [cds_pkg::LIMIT_W-1:0] cfg_wdata = '0;
	logic                        busy;
	logic                        done;
	logic [1:0]                  error_code;
	logic                        emitting_now;
	logic                        evaluate_next_elif;
	logic [6:0]                  open_levels;

	cds_pkg::frame_t             frame_shadow [cds_pkg::MAX_LEVELS];
	int                          depth_shadow;
	logic [cds_pkg::LIMIT_W-1:0] limit_shadow;
	result_t                     pending_results [$];
	result_t                     oldest;
	int                          mismatch_count = 0;
	int                          quiet_cycles = 0;
	bit                          no_gaps = 1'b0;

	conditional_directive_stack uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.action             (action),
		.condition          (condition),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.done               (done),
		.error_code         (error_code),
		.emitting_now       (emitting_now),
		.evaluate_next_elif (evaluate_next_elif),
		.open_levels        (open_levels)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic top_live();
		if (depth_shadow == 0)
			return 1'b1;
		return frame_shadow[depth_shadow-1].live;
	endfunction

	function automatic logic top_wants_elif();
		cds_pkg::frame_t f;
		if (depth_shadow == 0)
			return 1'b0;
		f = frame_shadow[depth_shadow-1];
		return f.parent && !f.taken && !f.else_seen;
	endfunction

	function automatic result_t predict_directive(cds_pkg::action_t act, logic cond);
		result_t         r;
		cds_pkg::frame_t f;
		int              lim;
		logic            lv;
		r.err = cds_pkg::ERR_NONE;
		lim = (limit_shadow < cds_pkg::MAX_LEVELS) ? int'(limit_shadow) :
			cds_pkg::MAX_LEVELS;
		if (act == cds_pkg::ACT_OPEN) begin
			if (depth_shadow >= lim) begin
				r.err = cds_pkg::ERR_NESTING;
			end else begin
				f = '0;
				if (top_live()) begin
					f.parent = 1'b1;
					f.live = cond;
					f.taken = cond;
				end
				frame_shadow[depth_shadow] = f;
				depth_shadow++;
			end
		end else if (depth_shadow == 0) begin
			r.err = cds_pkg::ERR_UNEXPECTED;
		end else if (act == cds_pkg::ACT_CLOSE) begin
			depth_shadow--;
		end else begin
			f = frame_shadow[depth_shadow-1];
			if (f.else_seen) begin
				r.err = cds_pkg::ERR_ELSE_AGAIN;
			end else begin
				if (act == cds_pkg::ACT_ELIF) begin
					lv = f.parent && !f.taken && cond;
					f.taken = f.taken || lv;
				end else begin
					lv = f.parent && !f.taken;
					f.taken = 1'b1;
					f.else_seen = 1'b1;
				end
				f.live = lv;
				frame_shadow[depth_shadow-1] = f;
			end
		end
		r.emit = top_live();
		r.want_elif = top_wants_elif();
		r.levels = depth_shadow[6:0];
		return r;
	endfunction

	// called at a rising edge, returns at the edge that takes the beat
	task automatic send_directive(cds_pkg::action_t act, logic cond);
		int   gap;
		logic ok;
		gap = no_gaps ? 0 : $urandom_range(16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		condition <= cond;
		do begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
		end while (!ok);
		pending_results = {pending_results, predict_directive(act, cond)};
	endtask

	task automatic pause_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic set_limit(logic [cds_pkg::LIMIT_W-1:0] value);
		pause_until_drained();
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		limit_shadow = value;
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed();
		no_gaps = 1'b0;
		send_directive(cds_pkg::ACT_CLOSE, 1'b1);
		send_directive(cds_pkg::ACT_ELIF, 1'b1);
		send_directive(cds_pkg::ACT_ELSE, 1'b0);
		send_directive(cds_pkg::ACT_OPEN, 1'b0);
		send_directive(cds_pkg::ACT_OPEN, 1'b1);
		send_directive(cds_pkg::ACT_ELIF, 1'b1);
		send_directive(cds_pkg::ACT_ELSE, 1'b1);
		send_directive(cds_pkg::ACT_CLOSE, 1'b0);
		send_directive(cds_pkg::ACT_ELIF, 1'b0);
		send_directive(cds_pkg::ACT_ELIF, 1'b1);
		send_directive(cds_pkg::ACT_ELIF, 1'b1);
		send_directive(cds_pkg::ACT_ELSE, 1'b0);
		send_directive(cds_pkg::ACT_ELIF, 1'b1);
		send_directive(cds_pkg::ACT_ELSE, 1'b1);
		send_directive(cds_pkg::ACT_CLOSE, 1'b1);
		send_directive(cds_pkg::ACT_OPEN, 1'b1);
		send_directive(cds_pkg::ACT_OPEN, 1'b1);
		send_directive(cds_pkg::ACT_ELSE, 1'b0);
		send_directive(cds_pkg::ACT_CLOSE, 1'b0);
		send_directive(cds_pkg::ACT_CLOSE, 1'b1);
	endtask

	task automatic test_limit_edges();
		no_gaps = 1'b1;
		set_limit(7'd0);
		send_directive(cds_pkg::ACT_OPEN, 1'b1);
		send_directive(cds_pkg::ACT_OPEN, 1'b0);
		send_directive(cds_pkg::ACT_ELIF, 1'b1);
		set_limit(7'd3);
		repeat (4) send_directive(cds_pkg::ACT_OPEN, 1'($urandom_range(1)));
		repeat (3) send_directive(cds_pkg::ACT_CLOSE, 1'b0);
		set_limit(7'd127);
		repeat (cds_pkg::MAX_LEVELS + 1)
			send_directive(cds_pkg::ACT_OPEN, 1'($urandom_range(1)));
		send_directive(cds_pkg::ACT_ELIF, 1'b1);
		send_directive(cds_pkg::ACT_ELSE, 1'b0);
		send_directive(cds_pkg::ACT_ELSE, 1'b1);
		repeat (cds_pkg::MAX_LEVELS + 1) send_directive(cds_pkg::ACT_CLOSE, 1'b1);
	endtask

	task automatic test_random_streams();
		logic [cds_pkg::LIMIT_W-1:0] limits [PHASES] = '{7'd64, 7'd1, 7'd2, 7'd8,
			7'd63, 7'd127, 7'd0, 7'd65, 7'd16, 7'd64};
		int               open_w;
		int               r;
		cds_pkg::action_t act;
		for (int p = 0; p < PHASES; p++) begin
			set_limit((p == 3) ? 7'($urandom_range(127)) : limits[p]);
			no_gaps = ($urandom_range(3) == 0);
			case ($urandom_range(2))
				0: open_w = 25;
				1: open_w = 35;
				default: open_w = 50;
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(99);
				if (r < 8)
					act = cds_pkg::action_t'($urandom_range(3));
				else if (depth_shadow == 0 || r < 8 + open_w)
					act = cds_pkg::ACT_OPEN;
				else if (r < 8 + open_w + 20)
					act = cds_pkg::ACT_ELIF;
				else if (r < 8 + open_w + 30)
					act = cds_pkg::ACT_ELSE;
				else
					act = cds_pkg::ACT_CLOSE;
				if (r >= 8 && (act == cds_pkg::ACT_ELIF || act == cds_pkg::ACT_ELSE) &&
						frame_shadow[depth_shadow-1].else_seen)
					act = cds_pkg::ACT_CLOSE;
				if ($urandom_range(99) == 0)
					pause_until_drained();
				send_directive(act, 1'($urandom_range(1)));
			end
		end
	endtask

	always @(negedge clk) begin
		if ((start && !busy) || done === 1'b1)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no directive pending");
				mismatch_count++;
			end else begin
				oldest = pending_results.pop_front();
				if (error_code !== oldest.err) begin
					$error("error_code: expected %0d, got %0d", oldest.err, error_code);
					mismatch_count++;
				end
				if (emitting_now !== oldest.emit) begin
					$error("emitting_now: expected %0d, got %0d", oldest.emit, emitting_now);
					mismatch_count++;
				end
				if (evaluate_next_elif !== oldest.want_elif) begin
					$error("evaluate_next_elif: expected %0d, got %0d", oldest.want_elif,
						evaluate_next_elif);
					mismatch_count++;
				end
				if (open_levels !== oldest.levels) begin
					$error("open_levels: expected %0d, got %0d", oldest.levels, open_levels);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		depth_shadow = 0;
		limit_shadow = cds_pkg::LIMIT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limit_edges();
		test_random_streams();
		pause_until_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
